@@ design/fcb_pkg.sv @@
// Shared types, hash constants and a helper function for the fingerprint collision block.
`timescale 1ns / 1ps

package fcb_pkg;

    localparam logic [63:0] FP_SALT   = 64'h0000_5050_4d44_3136;
    localparam logic [63:0] MIX_ADD   = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_MUL_A = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_MUL_B = 64'h94d0_49bb_1331_11eb;

    localparam int unsigned MAX_MATCH = 32;
    localparam logic [5:0]  NO_FIT    = 6'd33;

    // Number of registered stages between input acceptance and the operation queue.
    localparam int unsigned FRONT_STAGES = 5;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic       restart;
        logic       include_req;
        logic [5:0] need;
    } t_op;

    // Fewest low bits that separate two fingerprints, given their low-word difference.
    // All 32 bits equal means even 32 bits are not enough.
    function automatic logic [5:0] need_from_diff(input logic [MAX_MATCH-1:0] diff);
        logic [5:0] n;
        n = NO_FIT;
        for (int i = MAX_MATCH - 1; i >= 0; i--) begin
            if (diff[i]) begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

@@ design/fingerprint_collision_bits.sv @@
// Top level of the fingerprint collision block: front, operation queue and back.
`timescale 1ns / 1ps

// Takes one 16-bit candidate per cycle while full is low and, for each, returns one beat with
// the fewest low fingerprint bits that tell the target apart from every counted candidate of
// the query. Sustained rate is one item per clock while the result side is not stalled. An
// accepted item passes five registered stages of the fingerprint pipeline, the first loaded
// at acceptance, then the operation queue and then the output register. full rises once
// QUEUE_DEPTH items sit between acceptance and the queue read, so QUEUE_DEPTH should be at
// least seven for full rate. The target register may be written at any time; each item uses
// the target held when it is accepted.
module fingerprint_collision_bits
    import fcb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_candidate_value,
    input  logic        i_restart,
    input  logic        i_include_req,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  o_needed_bits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic w_q_push;
    logic w_q_pop;
    logic w_q_empty;
    t_op  w_q_in;
    t_op  w_q_out;

    assign o_cfg_ready = 1'b1;

    fcb_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_candidate_value (i_candidate_value),
        .i_restart         (i_restart),
        .i_include_req     (i_include_req),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_q_pop           (w_q_pop),
        .o_q_push          (w_q_push),
        .o_q_data          (w_q_in)
    );

    fcb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_out)
    );

    fcb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_q_data      (w_q_out),
        .o_q_pop       (w_q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_needed_bits (o_needed_bits)
    );

    // A waiting result never exceeds the no-fit code.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_needed_bits <= NO_FIT))
        else $error("needed_bits beyond the no-fit code");

    // With nothing queued, a taken beat leaves the result side empty.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_empty && pop && !empty) |=> empty)
        else $error("result beat appeared without a queued item");

    // Reset leaves both sides idle.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!full && empty))
        else $error("block not idle after reset");

endmodule

@@ design/fcb_queue.sv @@
// Small first-in first-out queue of classified operations between front and back.
`timescale 1ns / 1ps

module fcb_queue
    import fcb_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_data,
    input  logic i_pop,
    output logic o_empty,
    output t_op  o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_op           r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        q = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

@@ design/fcb_front.sv @@
// Front part: accepts items, fingerprints candidate and target, and classifies each item.
`timescale 1ns / 1ps

module fcb_front
    import fcb_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [15:0] i_candidate_value,
    input  logic        i_restart,
    input  logic        i_include_req,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    input  logic        i_q_pop,
    output logic        o_q_push,
    output t_op         o_q_data
);

    localparam int CW = $clog2(DEPTH + 1);

    // Lane 0 carries the candidate, lane 1 the target as it stood when the item came in.
    logic [15:0]   r_target;
    logic [CW-1:0] r_used;
    logic          w_accept;

    logic [FRONT_STAGES-1:0] r_vld;
    logic [FRONT_STAGES-1:0] r_rst;
    logic [FRONT_STAGES-1:0] r_inc;

    logic [63:0] r_v   [2];
    logic [63:0] r_pll [2];
    logic [31:0] r_phl [2];
    logic [31:0] r_plh [2];
    logic [63:0] r_y   [2];
    logic [63:0] r_qll [2];
    logic [31:0] r_qhl [2];
    logic [31:0] r_qlh [2];
    logic [63:0] r_w   [2];

    logic [63:0] n_v   [2];
    logic [63:0] x1    [2];
    logic [63:0] n_pll [2];
    logic [31:0] n_phl [2];
    logic [31:0] n_plh [2];
    logic [63:0] n_y   [2];
    logic [63:0] x2    [2];
    logic [63:0] n_qll [2];
    logic [31:0] n_qhl [2];
    logic [31:0] n_qlh [2];
    logic [63:0] n_w   [2];
    logic [31:0] fp_lo [2];

    assign w_accept = i_push && !o_full;
    // Credit covers every item between acceptance and the queue read, so the queue never overflows.
    assign o_full   = (r_used == CW'(DEPTH));

    always_comb begin
        n_v[0] = (64'(i_candidate_value) ^ FP_SALT) + MIX_ADD;
        n_v[1] = (64'(r_target) ^ FP_SALT) + MIX_ADD;
        for (int l = 0; l < 2; l++) begin
            // Low 64 bits of a 64 by 64 product, split into three 32 by 32 partial products.
            x1[l]    = r_v[l] ^ (r_v[l] >> 30);
            n_pll[l] = 64'(x1[l][31:0]) * 64'(MIX_MUL_A[31:0]);
            n_phl[l] = x1[l][63:32] * MIX_MUL_A[31:0];
            n_plh[l] = x1[l][31:0] * MIX_MUL_A[63:32];
            n_y[l]   = r_pll[l] + {r_phl[l] + r_plh[l], 32'b0};
            x2[l]    = r_y[l] ^ (r_y[l] >> 27);
            n_qll[l] = 64'(x2[l][31:0]) * 64'(MIX_MUL_B[31:0]);
            n_qhl[l] = x2[l][63:32] * MIX_MUL_B[31:0];
            n_qlh[l] = x2[l][31:0] * MIX_MUL_B[63:32];
            n_w[l]   = r_qll[l] + {r_qhl[l] + r_qlh[l], 32'b0};
            fp_lo[l] = r_w[l][31:0] ^ r_w[l][62:31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_used   <= '0;
            r_vld    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_target <= i_cfg_data;
            end
            if (w_accept && !i_q_pop) begin
                r_used <= r_used + 1'b1;
            end else if (!w_accept && i_q_pop) begin
                r_used <= r_used - 1'b1;
            end
            r_vld <= {r_vld[FRONT_STAGES-2:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rst <= {r_rst[FRONT_STAGES-2:0], i_restart};
        r_inc <= {r_inc[FRONT_STAGES-2:0], i_include_req};
        for (int l = 0; l < 2; l++) begin
            r_v[l]   <= n_v[l];
            r_pll[l] <= n_pll[l];
            r_phl[l] <= n_phl[l];
            r_plh[l] <= n_plh[l];
            r_y[l]   <= n_y[l];
            r_qll[l] <= n_qll[l];
            r_qhl[l] <= n_qhl[l];
            r_qlh[l] <= n_qlh[l];
            r_w[l]   <= n_w[l];
        end
    end

    assign o_q_push             = r_vld[FRONT_STAGES-1];
    assign o_q_data.restart     = r_rst[FRONT_STAGES-1];
    assign o_q_data.include_req = r_inc[FRONT_STAGES-1];
    assign o_q_data.need        = need_from_diff(fp_lo[0] ^ fp_lo[1]);

endmodule

@@ design/fcb_back.sv @@
// Back part: applies classified items to the running result and holds the output beat.
`timescale 1ns / 1ps

module fcb_back
    import fcb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_op        i_q_data,
    output logic       o_q_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [5:0] o_needed_bits
);

    logic [5:0] r_running;
    logic [5:0] r_out;
    logic       r_out_vld;
    logic [5:0] base;
    logic [5:0] n_running;

    // The output register frees up in the same cycle as its beat is taken.
    assign o_q_pop = !i_q_empty && (!r_out_vld || i_pop);

    always_comb begin
        base      = i_q_data.restart ? '0 : r_running;
        n_running = (i_q_data.include_req && (i_q_data.need > base)) ? i_q_data.need : base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_out_vld <= 1'b0;
        end else if (o_q_pop) begin
            r_running <= n_running;
            r_out_vld <= 1'b1;
        end else if (i_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= n_running;
        end
    end

    assign o_empty       = !r_out_vld;
    assign o_needed_bits = r_out;

endmodule
